FILE: rtl/dss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg
// Types and constants shared by the dot stuffing stream encoder modules.
// ----------------------------------------------------------------------------
package dss_pkg;

    // Largest number of result words that one input word can cause.
    localparam int unsigned MAX_RES = 5;
    localparam int unsigned NUM_W   = $clog2(MAX_RES + 1);
    localparam int unsigned IDX_W   = $clog2(MAX_RES);

    // Input word function codes.
    localparam logic FUNC_DATA   = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    // Characters of interest.
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;

    // Error codes carried in each result word.
    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_BARE_LF = 2'd1;
    localparam logic [1:0] ERR_BARE_CR = 2'd2;
    localparam logic [1:0] ERR_DONE    = 2'd3;

    typedef struct packed {
        logic       func;
        logic [7:0] in_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] error_code;
        logic       last;
    } out_word_t;

    // Encoder state kept between input words.
    typedef struct packed {
        logic at_line_start;
        logic cr_pending;
        logic stream_done;
    } enc_state_t;

    // Result words caused by one input word, waiting to be sent.
    typedef struct packed {
        logic [MAX_RES-1:0][7:0] seq;
        logic [NUM_W-1:0]        num;
        logic [1:0]              err;
    } burst_t;

endpackage

FILE: rtl/dss_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_encode
// Decides, for one input word, the result words it causes and the new state.
// ----------------------------------------------------------------------------
module dss_encode
(
    input  dss_pkg::enc_state_t state,
    input  dss_pkg::in_word_t   word,
    output dss_pkg::enc_state_t state_next,
    output dss_pkg::burst_t     burst
);
    import dss_pkg::*;

    always_comb
    begin
        state_next = state;
        burst      = '0;
        burst.err  = ERR_OK;

        if (state.stream_done)
        begin
            burst.num = NUM_W'(1);
            burst.err = ERR_DONE;
        end
        else if (word.func == FUNC_FINISH)
        begin
            if (state.cr_pending)
            begin
                burst.num = NUM_W'(1);
                burst.err = ERR_BARE_CR;
            end
            else
            begin
                state_next.stream_done = 1'b1;
                if (state.at_line_start)
                begin
                    burst.seq[0] = CH_DOT;
                    burst.seq[1] = CH_CR;
                    burst.seq[2] = CH_LF;
                    burst.num    = NUM_W'(3);
                end
                else
                begin
                    burst.seq[0] = CH_CR;
                    burst.seq[1] = CH_LF;
                    burst.seq[2] = CH_DOT;
                    burst.seq[3] = CH_CR;
                    burst.seq[4] = CH_LF;
                    burst.num    = NUM_W'(5);
                end
            end
        end
        else if (state.cr_pending)
        begin
            if (word.in_byte != CH_LF)
            begin
                burst.num = NUM_W'(1);
                burst.err = ERR_BARE_CR;
            end
            else
            begin
                state_next.cr_pending    = 1'b0;
                state_next.at_line_start = 1'b1;
                burst.seq[0] = CH_CR;
                burst.seq[1] = CH_LF;
                burst.num    = NUM_W'(2);
            end
        end
        else if (word.in_byte == CH_LF)
        begin
            burst.num = NUM_W'(1);
            burst.err = ERR_BARE_LF;
        end
        else if (word.in_byte == CH_CR)
        begin
            // The CR is held back until its LF arrives; nothing is sent yet.
            state_next.cr_pending = 1'b1;
        end
        else
        begin
            state_next.at_line_start = 1'b0;
            burst.seq[0] = word.in_byte;
            if (state.at_line_start && word.in_byte == CH_DOT)
            begin
                burst.seq[1] = CH_DOT;
                burst.num    = NUM_W'(2);
            end
            else
            begin
                burst.num = NUM_W'(1);
            end
        end
    end

endmodule

FILE: rtl/dot_stuffing_stream_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_stuffing_stream_encoder
// Mail body encoder with dot transparency, one byte per input word.
// ----------------------------------------------------------------------------
// The block takes a mail body one byte per word and sends the wire bytes one
// per result word. An ordinary byte gives one result word, and a new input
// word is taken in every cycle while results flow. A dot at the start of a
// line and a CR LF pair each give two result words, the terminator three or
// five; the output register sends one byte per cycle unless the receiver
// stalls, and that serializer sets the rate. A CR word produces nothing. A
// rejected word gives one result word with a zero byte, its error code and
// last set, and leaves the state as it was. Once the stream is finished,
// every further word is rejected as already finished until reset.
module dot_stuffing_stream_encoder
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               src_valid,
    output logic               src_stall,
    input  dss_pkg::in_word_t  src_word,
    output logic               dst_valid,
    input  logic               dst_stall,
    output dss_pkg::out_word_t dst_word
);
    import dss_pkg::*;

    enc_state_t       state_reg;
    enc_state_t       state_next;
    burst_t           burst_next;
    burst_t           burst_reg;
    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             src_take;
    logic             dst_take;
    logic             burst_last;
    logic             burst_free;

    // The encoder looks at the incoming word and the current line state and
    // decides all result words for it in one pass.
    dss_encode u_encode
    (
        .state      (state_reg),
        .word       (src_word),
        .state_next (state_next),
        .burst      (burst_next)
    );

    // The current result word is the last one of its burst when the index has
    // reached the burst length less one.
    assign burst_last = ({1'b0, idx_reg} == (NUM_W + 1)'(burst_reg.num) - (NUM_W + 1)'(1));
    assign dst_take   = busy_reg && !dst_stall;

    // The burst register frees up in the cycle its last word is taken, so a
    // new word can enter right behind it without a bubble.
    assign burst_free = !busy_reg || (dst_take && burst_last);
    assign src_stall  = !burst_free;
    assign src_take   = src_valid && !src_stall;

    assign dst_valid           = busy_reg;
    assign dst_word.out_byte   = burst_reg.seq[idx_reg];
    assign dst_word.error_code = burst_reg.err;
    assign dst_word.last       = burst_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.at_line_start <= 1'b1;
            state_reg.cr_pending    <= 1'b0;
            state_reg.stream_done   <= 1'b0;
            busy_reg                <= 1'b0;
            idx_reg                 <= '0;
        end
        else
        begin
            if (src_take)
            begin
                state_reg <= state_next;
            end

            if (src_take)
            begin
                // A held CR produces no result, so the register stays empty.
                busy_reg <= (burst_next.num != '0);
                idx_reg  <= '0;
            end
            else if (dst_take)
            begin
                if (burst_last)
                begin
                    busy_reg <= 1'b0;
                    idx_reg  <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
        end
    end

    // Burst payload needs no reset; it is only read while busy_reg is set.
    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            burst_reg <= burst_next;
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking regression for the dot stuffing stream encoder.
// ----------------------------------------------------------------------------
// A directed table covers the byte extremes, every error code, held CR
// handling, dot doubling and the end of stream. It is followed by a long run
// of random mail lines mixed with malformed traffic. Every accepted input word
// is fed to a local encoder model, which queues the wire bytes it expects. Each
// output word is checked field by field against the oldest queued entry. The
// sender idles in bursts, and the receiver stalls according to a changing
// pattern.
// ----------------------------------------------------------------------------
module tb_top;

    import dss_pkg::*;

    // The slowest legal run stays well under this number of cycles.
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned RANDOM_WORDS = 500;
    // Extra cycles allowed after the last expected word before ending.
    localparam int unsigned DRAIN_CYCLES = 12;

    localparam out_word_t NO_RES = '0;

    // One row of the directed table. When typed is set, res holds the single
    // result word expected. Otherwise the local model decides.
    typedef struct packed {
        in_word_t  word;
        logic      typed;
        out_word_t res;
    } dir_row_t;

    // The same check tag, queued for each word as it is offered.
    typedef struct packed {
        logic      typed;
        out_word_t res;
    } row_check_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_HALF,
        STALL_HEAVY,
        STALL_EVERY3
    } stall_mode_e;

    // The finish word closes the stream until reset, and reset is applied only
    // once. For that reason the rows from DIR_HEAD onward run after the random
    // part.
    localparam int DIR_HEAD = 18;
    localparam int DIR_ROWS = 23;

    localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
        // The line is open after reset, and the extreme bytes pass through as-is.
        '{'{FUNC_DATA,   8'h00},  1'b1, '{8'h00, ERR_OK,      1'b1}},
        '{'{FUNC_DATA,   8'hFF},  1'b1, '{8'hFF, ERR_OK,      1'b1}},
        // An LF with no CR before it.
        '{'{FUNC_DATA,   CH_LF},  1'b1, '{8'h00, ERR_BARE_LF, 1'b1}},
        // Hold a CR, then try a byte other than LF, a second CR and a finish.
        '{'{FUNC_DATA,   CH_CR},  1'b0, NO_RES},
        '{'{FUNC_DATA,   8'h58},  1'b1, '{8'h00, ERR_BARE_CR, 1'b1}},
        '{'{FUNC_DATA,   CH_CR},  1'b1, '{8'h00, ERR_BARE_CR, 1'b1}},
        '{'{FUNC_FINISH, 8'h00},  1'b1, '{8'h00, ERR_BARE_CR, 1'b1}},
        // The LF releases the held CR as a pair.
        '{'{FUNC_DATA,   CH_LF},  1'b0, NO_RES},
        // A dot at line start is doubled. The one after it is not.
        '{'{FUNC_DATA,   CH_DOT}, 1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_DOT}, 1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_CR},  1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_LF},  1'b0, NO_RES},
        // Empty line, then a leading dot once more.
        '{'{FUNC_DATA,   CH_CR},  1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_LF},  1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_DOT}, 1'b0, NO_RES},
        '{'{FUNC_DATA,   8'h61},  1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_CR},  1'b0, NO_RES},
        '{'{FUNC_DATA,   CH_LF},  1'b0, NO_RES},
        // Closing rows. The terminator form depends on where the random part
        // left the line. After that, every word is refused.
        '{'{FUNC_FINISH, 8'h00},  1'b0, NO_RES},
        '{'{FUNC_DATA,   8'h41},  1'b1, '{8'h00, ERR_DONE,    1'b1}},
        '{'{FUNC_FINISH, 8'hFF},  1'b1, '{8'h00, ERR_DONE,    1'b1}},
        '{'{FUNC_DATA,   CH_CR},  1'b1, '{8'h00, ERR_DONE,    1'b1}},
        '{'{FUNC_DATA,   CH_LF},  1'b1, '{8'h00, ERR_DONE,    1'b1}}
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        src_valid = 1'b0;
    logic        src_stall;
    in_word_t    src_word  = '0;
    logic        dst_valid;
    logic        dst_stall = 1'b0;
    out_word_t   dst_word;

    // Local copy of the encoder state.
    logic        enc_bol      = 1'b1;
    logic        enc_cr_held  = 1'b0;
    logic        enc_closed   = 1'b0;

    // Wire bytes that are still to arrive, oldest first.
    out_word_t   wire_due[$];
    row_check_t  row_checks[$];

    int unsigned cycle_count = 0;
    int unsigned fail_count  = 0;
    int unsigned burst_left  = 0;

    stall_mode_e stall_mode  = STALL_NONE;
    int unsigned stall_span  = 0;
    int unsigned stall_phase = 0;

    row_check_t  acc_check;
    out_word_t   due_word;
    out_word_t   got_word;

    dot_stuffing_stream_encoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Apply dot transparency to one accepted word and update the local state.
    // If queue_it is set, the resulting wire bytes are queued as expected.
    // A rejected word gives a single zero byte that carries its error code.
    task automatic encode_word(input in_word_t w, input logic queue_it);
        logic [7:0] seq[$];
        logic [1:0] err;
        err = ERR_OK;
        if (enc_closed)
        begin
            seq = '{8'h00};
            err = ERR_DONE;
        end
        else if (w.func == FUNC_FINISH)
        begin
            if (enc_cr_held)
            begin
                seq = '{8'h00};
                err = ERR_BARE_CR;
            end
            else
            begin
                enc_closed = 1'b1;
                if (enc_bol)
                    seq = '{CH_DOT, CH_CR, CH_LF};
                else
                    seq = '{CH_CR, CH_LF, CH_DOT, CH_CR, CH_LF};
            end
        end
        else if (enc_cr_held)
        begin
            // Only an LF can follow a held CR. Anything else is refused, and
            // the CR stays held.
            if (w.in_byte != CH_LF)
            begin
                seq = '{8'h00};
                err = ERR_BARE_CR;
            end
            else
            begin
                enc_cr_held = 1'b0;
                enc_bol     = 1'b1;
                seq         = '{CH_CR, CH_LF};
            end
        end
        else if (w.in_byte == CH_LF)
        begin
            seq = '{8'h00};
            err = ERR_BARE_LF;
        end
        else if (w.in_byte == CH_CR)
        begin
            enc_cr_held = 1'b1;
        end
        else if (enc_bol && w.in_byte == CH_DOT)
        begin
            enc_bol = 1'b0;
            seq     = '{CH_DOT, CH_DOT};
        end
        else
        begin
            enc_bol = 1'b0;
            seq     = '{w.in_byte};
        end
        if (queue_it)
            foreach (seq[k])
                wire_due.push_back(out_word_t'{seq[k], err, (k == seq.size() - 1)});
    endtask

    // Offer one word and hold it until it is taken. Bursts of back-to-back
    // words are separated by gaps of random length, and a long burst now and
    // then gives stretches with no idling.
    task automatic send_word(input in_word_t w, input logic typed, input out_word_t res);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                src_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 100);
            else
                burst_left = $urandom_range(1, 16);
        end
        row_checks.push_back(row_check_t'{typed, res});
        src_valid <= 1'b1;
        src_word  <= w;
        do
            @(posedge clk);
        while (src_stall);
        burst_left--;
    endtask

    task automatic send_data(input logic [7:0] b);
        send_word(in_word_t'{FUNC_DATA, b}, 1'b0, NO_RES);
    endtask

    // A body byte that is never CR or LF. Dots are made more likely so that
    // they also show up inside lines.
    function automatic logic [7:0] body_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            b = CH_DOT;
        else if (b == CH_CR || b == CH_LF)
            b = b ^ 8'h40;
        return b;
    endfunction

    // Run the model on each accepted word, then check each accepted result.
    // Doing both in one process at the clock edge keeps the order fixed when
    // both happen on the same edge. Values read here are those from before
    // the edge.
    always @(posedge clk)
    begin
        if (rst_n && src_valid && !src_stall)
        begin
            acc_check = row_checks.pop_front();
            encode_word(src_word, !acc_check.typed);
            if (acc_check.typed)
                wire_due.push_back(acc_check.res);
        end
        if (rst_n && dst_valid && !dst_stall)
        begin
            got_word = dst_word;
            if (wire_due.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual byte %h code %0d last %b",
                         $time, got_word.out_byte, got_word.error_code, got_word.last);
                fail_count++;
            end
            else
            begin
                due_word = wire_due.pop_front();
                if (got_word.out_byte !== due_word.out_byte)
                begin
                    $display("%0t: out_byte mismatch: expected %h, actual %h",
                             $time, due_word.out_byte, got_word.out_byte);
                    fail_count++;
                end
                if (got_word.error_code !== due_word.error_code)
                begin
                    $display("%0t: error_code mismatch: expected %0d, actual %0d",
                             $time, due_word.error_code, got_word.error_code);
                    fail_count++;
                end
                if (got_word.last !== due_word.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, due_word.last, got_word.last);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure. The pattern switches at random among no stall,
    // about half, heavy, and a periodic stall set by a phase counter.
    always @(posedge clk)
    begin
        if (stall_span == 0)
        begin
            stall_mode <= stall_mode_e'($urandom_range(0, 3));
            stall_span <= $urandom_range(8, 60);
        end
        else
        begin
            stall_span <= stall_span - 1;
        end
        stall_phase <= (stall_phase == 2) ? 0 : stall_phase + 1;
        case (stall_mode)
            STALL_NONE:   dst_stall <= 1'b0;
            STALL_HALF:   dst_stall <= ($urandom_range(0, 1) == 1);
            STALL_HEAVY:  dst_stall <= ($urandom_range(0, 9) < 8);
            STALL_EVERY3: dst_stall <= (stall_phase == 0);
            default:      dst_stall <= 1'b0;
        endcase
    end

    // Overall watchdog on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words still due", cycle_count,
                     wire_due.size());
            $display("dot_stuffing_stream_encoder regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned n_words;
        int unsigned len;
        int unsigned pick;
        n_words = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_HEAD; i++)
            send_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].res);

        // The random part mostly sends well-formed lines, each ending in CR LF,
        // with a leading dot on about a quarter of them. The rest is malformed
        // traffic. A finish is sent only right after a CR, so that it is
        // refused as a bare CR and the stream stays open until the closing
        // rows.
        while (n_words < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 8)
            begin
                len = $urandom_range(0, 10);
                if ($urandom_range(0, 3) == 0)
                begin
                    send_data(CH_DOT);
                    n_words++;
                end
                repeat (len) send_data(body_byte());
                send_data(CH_CR);
                send_data(CH_LF);
                n_words += len + 2;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_data(CH_LF);
                        n_words++;
                    end
                    1:
                    begin
                        send_data(CH_CR);
                        send_data(8'($urandom_range(0, 255)));
                        send_data(CH_LF);
                        n_words += 3;
                    end
                    2:
                    begin
                        send_data(CH_CR);
                        send_word(in_word_t'{FUNC_FINISH, 8'($urandom_range(0, 255))},
                                  1'b0, NO_RES);
                        send_data(CH_LF);
                        n_words += 3;
                    end
                    default:
                    begin
                        // Any byte at all, a stray CR among them.
                        send_data(8'($urandom_range(0, 255)));
                        n_words++;
                    end
                endcase
            end
        end

        // Release any held CR. Then leave the line either open at its start
        // or in the middle, so that across seeds both terminators are sent.
        send_data(CH_LF);
        if ($urandom_range(0, 1) == 0)
        begin
            send_data(CH_CR);
            send_data(CH_LF);
        end
        else
        begin
            send_data(8'h5A);
        end

        for (int i = DIR_HEAD; i < DIR_ROWS; i++)
            send_word(DIR_TAB[i].word, DIR_TAB[i].typed, DIR_TAB[i].res);
        src_valid <= 1'b0;

        // Let the checker take in the last word before looking at the queue.
        @(posedge clk);
        while (wire_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (wire_due.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, wire_due.size());
            fail_count++;
        end

        if (fail_count == 0)
            $display("dot_stuffing_stream_encoder regression: pass");
        else
            $display("dot_stuffing_stream_encoder regression: fail");
        $finish;
    end

endmodule
